[design/yuvrgb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes and conversion coefficients for the YUV 4:2:0 to RGB block.
package yuvrgb_pkg;

    // Coefficients in thousandths
    localparam longint MILLI_Y  = 1164;
    localparam longint MILLI_RV = 1596;
    localparam longint MILLI_GU = 391;
    localparam longint MILLI_GV = 813;
    localparam longint MILLI_BU = 2018;

    localparam longint LUMA_OFFSET   = 16;
    localparam longint CHROMA_OFFSET = 128;

    localparam int SAMPLE_W    = 8;
    localparam int PIXEL_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OUTPUT_MODE = 2'd0,
        REG_RGBA_ORDER  = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_OPAQUE      = 2'd0,
        MODE_RGB24       = 2'd1,
        MODE_ALPHA_PLANE = 2'd2
    } out_mode_t;

    // trunc(t * (milli/1000 * 2^f + 0.5)), evaluated at elaboration
    function automatic longint table_term(longint milli, longint t, int f);
        longint scale;
        longint num;
        scale = longint'(1) << f;
        num   = t * (2 * milli * scale + 1000);
        return num / 2000;
    endfunction

endpackage

[design/yuvrgb_rom.sv]
`timescale 1ns / 1ps
// Coefficient ROM with registered read: one signed term per 8-bit sample value.
module yuvrgb_rom
    import yuvrgb_pkg::*;
#(
    parameter int     FRACTION_BITS = 13,
    parameter int     TERM_W        = 23,
    parameter longint MILLI         = 1164,
    parameter longint OFFSET        = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [SAMPLE_W-1:0]      rd_addr,
    output logic signed [TERM_W-1:0] rd_data
);

    localparam int DEPTH = 1 << SAMPLE_W;

    logic signed [TERM_W-1:0] rom [DEPTH];
    logic signed [TERM_W-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam longint VALUE = table_term(MILLI, longint'(i) - OFFSET, FRACTION_BITS);
        assign rom[i] = TERM_W'(VALUE);
    end

    // hold the last read while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/yuvrgb_pixel.sv]
`timescale 1ns / 1ps
// Channel sums, floor shift, clip to a byte and byte packing for one pixel.
module yuvrgb_pixel
    import yuvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 13,
    parameter int TERM_W        = 23,
    parameter int SUM_W         = 24
) (
    input  logic signed [TERM_W-1:0] y_term,
    input  logic signed [TERM_W-1:0] rv_term,
    input  logic signed [TERM_W-1:0] gu_term,
    input  logic signed [TERM_W-1:0] gv_term,
    input  logic signed [TERM_W-1:0] bu_term,
    input  logic signed [TERM_W-1:0] alpha_y_term,
    input  logic signed [TERM_W-1:0] alpha_rv_term,
    input  out_mode_t                mode,
    input  logic                     rgba_order,
    output logic [PIXEL_W-1:0]       pixel
);

    localparam int INT_W = SUM_W - FRACTION_BITS;

    function automatic logic [SAMPLE_W-1:0] clip_byte(logic signed [SUM_W-1:0] x);
        logic [INT_W-1:0] whole;
        whole = x[SUM_W-1:FRACTION_BITS];
        if (x[SUM_W-1]) begin
            return '0;
        end else if (whole > INT_W'(255)) begin
            return 8'hFF;
        end
        return whole[SAMPLE_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;
    logic signed [SUM_W-1:0] a_sum;
    logic [SAMPLE_W-1:0]     r_byte;
    logic [SAMPLE_W-1:0]     g_byte;
    logic [SAMPLE_W-1:0]     b_byte;
    logic [SAMPLE_W-1:0]     a_byte;

    always_comb begin
        r_sum  = SUM_W'(y_term) + SUM_W'(rv_term);
        g_sum  = SUM_W'(y_term) - SUM_W'(gu_term) - SUM_W'(gv_term);
        b_sum  = SUM_W'(y_term) + SUM_W'(bu_term);
        a_sum  = SUM_W'(alpha_y_term) + SUM_W'(alpha_rv_term);
        r_byte = clip_byte(r_sum);
        g_byte = clip_byte(g_sum);
        b_byte = clip_byte(b_sum);
        case (mode)
            MODE_RGB24:       a_byte = '0;
            MODE_ALPHA_PLANE: a_byte = clip_byte(a_sum);
            default:          a_byte = 8'hFF;
        endcase
        if (rgba_order) begin
            pixel = {a_byte, b_byte, g_byte, r_byte};
        end else begin
            pixel = {a_byte, r_byte, g_byte, b_byte};
        end
    end

endmodule

[design/yuv420_block_to_rgb_pixels.sv]
`timescale 1ns / 1ps
// Top level: YUV 4:2:0 2x2 block to four packed RGB/RGBA pixels.
//
// Usage
//   Input channel (s_*): one request carries a 2x2 block of the colour frame
//   (four luma samples, shared U and V) and the matching alpha block (four
//   luma samples and its V sample). Output channel (m_*): one request carries
//   the four packed 32-bit pixels of that block.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 output mode, 1 byte order); other indexes are dropped. Write only
//   while no block is in flight.
//   Pipeline: two register stages. The accepting edge loads the ROM stage and
//   the next advancing edge the output register, which raises m_valid.
//   Throughput: one block per cycle while m_ready is high or no result is
//   held, set by the two-stage pipeline of coefficient ROM reads followed
//   by the sum, clip and pack stage into the output register.
//   Reset (aresetn low, synchronous): the pipeline empties and both
//   registers return to zero (opaque alpha, blue in byte 0).
//   Stall: while m_ready is low with a result held, the whole pipeline holds
//   and s_ready falls; s_ready follows m_ready in the same cycle.
module yuv420_block_to_rgb_pixels
    import yuvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 13
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_luma_top_left,
    input  logic [SAMPLE_W-1:0]    s_luma_top_right,
    input  logic [SAMPLE_W-1:0]    s_luma_bottom_left,
    input  logic [SAMPLE_W-1:0]    s_luma_bottom_right,
    input  logic [SAMPLE_W-1:0]    s_chroma_u,
    input  logic [SAMPLE_W-1:0]    s_chroma_v,
    input  logic [SAMPLE_W-1:0]    s_alpha_luma_top_left,
    input  logic [SAMPLE_W-1:0]    s_alpha_luma_top_right,
    input  logic [SAMPLE_W-1:0]    s_alpha_luma_bottom_left,
    input  logic [SAMPLE_W-1:0]    s_alpha_luma_bottom_right,
    input  logic [SAMPLE_W-1:0]    s_alpha_chroma_v,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIXEL_W-1:0]     m_pixel_top_left,
    output logic [PIXEL_W-1:0]     m_pixel_top_right,
    output logic [PIXEL_W-1:0]     m_pixel_bottom_left,
    output logic [PIXEL_W-1:0]     m_pixel_bottom_right
);

    // Terms reach about +/-278 in integer units, channel sums about 536
    localparam int TERM_W   = FRACTION_BITS + 10;
    localparam int SUM_W    = FRACTION_BITS + 11;
    localparam int NUM_PIX  = 4;
    localparam int NUM_LUMA = 2 * NUM_PIX;

    // Configuration registers
    out_mode_t mode_reg;
    logic      rgba_order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_OPAQUE;
            rgba_order_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_OUTPUT_MODE: mode_reg       <= out_mode_t'(cfg_wdata);
                REG_RGBA_ORDER:  rgba_order_reg <= cfg_wdata[0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Pipeline control: advance whenever the output register is free or
    // being taken this cycle
    logic advance;
    logic rom_valid_reg;
    logic out_valid_reg;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            rom_valid_reg <= s_valid;
            out_valid_reg <= rom_valid_reg;
        end
    end

    // Stage 1: coefficient ROM reads. Colour lumas in slots 0..3, alpha
    // lumas in slots 4..7, same pixel order.
    logic [SAMPLE_W-1:0]      luma_addr [NUM_LUMA];
    logic signed [TERM_W-1:0] y_term    [NUM_LUMA];
    logic signed [TERM_W-1:0] rv_term;
    logic signed [TERM_W-1:0] gu_term;
    logic signed [TERM_W-1:0] gv_term;
    logic signed [TERM_W-1:0] bu_term;
    logic signed [TERM_W-1:0] alpha_rv_term;

    assign luma_addr[0] = s_luma_top_left;
    assign luma_addr[1] = s_luma_top_right;
    assign luma_addr[2] = s_luma_bottom_left;
    assign luma_addr[3] = s_luma_bottom_right;
    assign luma_addr[4] = s_alpha_luma_top_left;
    assign luma_addr[5] = s_alpha_luma_top_right;
    assign luma_addr[6] = s_alpha_luma_bottom_left;
    assign luma_addr[7] = s_alpha_luma_bottom_right;

    for (genvar k = 0; k < NUM_LUMA; k++) begin : g_luma_rom
        yuvrgb_rom #(
            .FRACTION_BITS (FRACTION_BITS),
            .TERM_W        (TERM_W),
            .MILLI         (MILLI_Y),
            .OFFSET        (LUMA_OFFSET)
        ) u_rom (
            .aclk    (aclk),
            .rd_en   (advance),
            .rd_addr (luma_addr[k]),
            .rd_data (y_term[k])
        );
    end

    yuvrgb_rom #(
        .FRACTION_BITS (FRACTION_BITS),
        .TERM_W        (TERM_W),
        .MILLI         (MILLI_RV),
        .OFFSET        (CHROMA_OFFSET)
    ) u_rv_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s_chroma_v),
        .rd_data (rv_term)
    );

    yuvrgb_rom #(
        .FRACTION_BITS (FRACTION_BITS),
        .TERM_W        (TERM_W),
        .MILLI         (MILLI_GU),
        .OFFSET        (CHROMA_OFFSET)
    ) u_gu_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s_chroma_u),
        .rd_data (gu_term)
    );

    yuvrgb_rom #(
        .FRACTION_BITS (FRACTION_BITS),
        .TERM_W        (TERM_W),
        .MILLI         (MILLI_GV),
        .OFFSET        (CHROMA_OFFSET)
    ) u_gv_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s_chroma_v),
        .rd_data (gv_term)
    );

    yuvrgb_rom #(
        .FRACTION_BITS (FRACTION_BITS),
        .TERM_W        (TERM_W),
        .MILLI         (MILLI_BU),
        .OFFSET        (CHROMA_OFFSET)
    ) u_bu_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s_chroma_u),
        .rd_data (bu_term)
    );

    // Alpha term uses the red-channel coefficient on the alpha block's V
    yuvrgb_rom #(
        .FRACTION_BITS (FRACTION_BITS),
        .TERM_W        (TERM_W),
        .MILLI         (MILLI_RV),
        .OFFSET        (CHROMA_OFFSET)
    ) u_alpha_rv_rom (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s_alpha_chroma_v),
        .rd_data (alpha_rv_term)
    );

    // Stage 2: sum, clip and pack each pixel into the output register
    logic [PIXEL_W-1:0] pixel_next [NUM_PIX];
    logic [PIXEL_W-1:0] pixel_reg  [NUM_PIX];

    for (genvar k = 0; k < NUM_PIX; k++) begin : g_pixel
        yuvrgb_pixel #(
            .FRACTION_BITS (FRACTION_BITS),
            .TERM_W        (TERM_W),
            .SUM_W         (SUM_W)
        ) u_pixel (
            .y_term        (y_term[k]),
            .rv_term       (rv_term),
            .gu_term       (gu_term),
            .gv_term       (gv_term),
            .bu_term       (bu_term),
            .alpha_y_term  (y_term[k + NUM_PIX]),
            .alpha_rv_term (alpha_rv_term),
            .mode          (mode_reg),
            .rgba_order    (rgba_order_reg),
            .pixel         (pixel_next[k])
        );

        // hold the packed result while the receiver stalls
        always_ff @(posedge aclk) begin
            if (advance) begin
                pixel_reg[k] <= pixel_next[k];
            end
        end
    end

    assign m_pixel_top_left     = pixel_reg[0];
    assign m_pixel_top_right    = pixel_reg[1];
    assign m_pixel_bottom_left  = pixel_reg[2];
    assign m_pixel_bottom_right = pixel_reg[3];

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the YUV 4:2:0 block to RGB pixel converter.
module testbench;
    import yuvrgb_pkg::*;

    localparam int FRAC_BITS     = 13;
    localparam int IDLE_PERCENT  = 37;
    localparam int SETTLE_CYCLES = 4;     // pipeline is two deep; leave margin
    localparam int TAIL_CYCLES   = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BLOCKS = 1250;
    localparam int REPORT_LIMIT  = 10;

    // Selector and register codes that the package leaves unnamed
    localparam logic [1:0]             MODE_SPARE   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        REQ_BLOCK,
        REQ_CONFIG,
        REQ_PAUSE
    } req_kind_t;

    // Pixel order in every array below: top left, top right, bottom left, bottom right
    typedef struct packed {
        logic [3:0][SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0]      chroma_u;
        logic [SAMPLE_W-1:0]      chroma_v;
        logic [3:0][SAMPLE_W-1:0] alpha_luma;
        logic [SAMPLE_W-1:0]      alpha_chroma_v;
    } yuv_block_t;

    typedef logic [3:0][PIXEL_W-1:0] pixel_quad_t;

    typedef struct {
        req_kind_t              kind;
        yuv_block_t             block;
        logic [CFG_INDEX_W-1:0] cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_data;
        bit                     calm;
    } pending_req_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    yuv_block_t             s_block      = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [PIXEL_W-1:0]     m_pixel_top_left;
    logic [PIXEL_W-1:0]     m_pixel_top_right;
    logic [PIXEL_W-1:0]     m_pixel_bottom_left;
    logic [PIXEL_W-1:0]     m_pixel_bottom_right;

    pending_req_t pending_requests[$];
    pixel_quad_t  expected_pixels[$];

    logic       req_taken    = 1'b0;   // request accepted at the last rising edge
    logic       calm_stretch = 1'b0;   // no idling on either side while set
    logic [1:0] mode_shadow  = 2'd0;
    logic       order_shadow = 1'b0;
    int         quiet_cycles = 0;
    int         stall_cycles = 0;
    int         error_count  = 0;
    int         results_seen = 0;
    int         cfg_writes   = 0;
    int         mode_hits[4] = '{0, 0, 0, 0};

    yuv420_block_to_rgb_pixels #(
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .cfg_wr_en                 (cfg_wr_en),
        .cfg_index                 (cfg_index),
        .cfg_wdata                 (cfg_wdata),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_luma_top_left           (s_block.luma[0]),
        .s_luma_top_right          (s_block.luma[1]),
        .s_luma_bottom_left        (s_block.luma[2]),
        .s_luma_bottom_right       (s_block.luma[3]),
        .s_chroma_u                (s_block.chroma_u),
        .s_chroma_v                (s_block.chroma_v),
        .s_alpha_luma_top_left     (s_block.alpha_luma[0]),
        .s_alpha_luma_top_right    (s_block.alpha_luma[1]),
        .s_alpha_luma_bottom_left  (s_block.alpha_luma[2]),
        .s_alpha_luma_bottom_right (s_block.alpha_luma[3]),
        .s_alpha_chroma_v          (s_block.alpha_chroma_v),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_pixel_top_left          (m_pixel_top_left),
        .m_pixel_top_right         (m_pixel_top_right),
        .m_pixel_bottom_left       (m_pixel_bottom_left),
        .m_pixel_bottom_right      (m_pixel_bottom_right)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Pixel predictor
    // ---------------------------------------------------------------

    // Offset sample times (k * 2^F + 0.5), truncated toward zero.
    // The coefficient is held scaled by 2000 so the sum stays exact.
    function automatic longint scaled_term(longint milli, longint t);
        longint coef2000;
        longint mag;
        coef2000 = 2 * milli * (longint'(1) << FRAC_BITS) + 1000;
        mag      = ((t < 0) ? -t : t) * coef2000 / 2000;
        return (t < 0) ? -mag : mag;
    endfunction

    // Floor the fixed-point sum to an integer, then saturate to a byte
    function automatic logic [7:0] to_byte(longint acc);
        longint whole;
        whole = acc >>> FRAC_BITS;
        if (whole < 0)
            return 8'd0;
        if (whole > 255)
            return 8'd255;
        return whole[7:0];
    endfunction

    function automatic longint luma_part(logic [SAMPLE_W-1:0] y);
        return scaled_term(MILLI_Y, longint'(y) - LUMA_OFFSET);
    endfunction

    function automatic pixel_quad_t convert_block(yuv_block_t blk, logic [1:0] mode,
                                                  logic red_first);
        longint      red_c;
        longint      green_c;
        longint      blue_c;
        longint      alpha_c;
        longint      y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        pixel_quad_t quad;
        red_c   = scaled_term(MILLI_RV, longint'(blk.chroma_v) - CHROMA_OFFSET);
        green_c = scaled_term(MILLI_GU, longint'(blk.chroma_u) - CHROMA_OFFSET)
                + scaled_term(MILLI_GV, longint'(blk.chroma_v) - CHROMA_OFFSET);
        blue_c  = scaled_term(MILLI_BU, longint'(blk.chroma_u) - CHROMA_OFFSET);
        alpha_c = scaled_term(MILLI_RV, longint'(blk.alpha_chroma_v) - CHROMA_OFFSET);
        for (int k = 0; k < 4; k++) begin
            y = luma_part(blk.luma[k]);
            r = to_byte(y + red_c);
            g = to_byte(y - green_c);
            b = to_byte(y + blue_c);
            case (mode)
                MODE_RGB24:       a = 8'd0;
                MODE_ALPHA_PLANE: a = to_byte(luma_part(blk.alpha_luma[k]) + alpha_c);
                default:          a = 8'd255;    // opaque, also the spare selector
            endcase
            quad[k] = red_first ? {a, b, g, r} : {a, r, g, b};
        end
        return quad;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_block(yuv_block_t blk, bit calm);
        pending_req_t req;
        req.kind      = REQ_BLOCK;
        req.block     = blk;
        req.cfg_index = '0;
        req.cfg_data  = '0;
        req.calm      = calm;
        pending_requests.push_back(req);
    endtask

    task automatic queue_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        pending_req_t req;
        req.kind      = REQ_CONFIG;
        req.block     = '0;
        req.cfg_index = idx;
        req.cfg_data  = data;
        req.calm      = 1'b0;
        pending_requests.push_back(req);
    endtask

    // Flat block: every luma the same, every alpha luma the same
    function automatic yuv_block_t flat_block(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                              logic [7:0] ay, logic [7:0] av);
        yuv_block_t blk;
        blk.luma           = {4{y}};
        blk.chroma_u       = u;
        blk.chroma_v       = v;
        blk.alpha_luma     = {4{ay}};
        blk.alpha_chroma_v = av;
        return blk;
    endfunction

    // Lean on the rails now and then so that clipping is hit often
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic yuv_block_t random_block();
        yuv_block_t blk;
        for (int k = 0; k < 4; k++) begin
            blk.luma[k]       = pick_sample();
            blk.alpha_luma[k] = pick_sample();
        end
        blk.chroma_u       = pick_sample();
        blk.chroma_v       = pick_sample();
        blk.alpha_chroma_v = pick_sample();
        return blk;
    endfunction

    task automatic note_error(string msg);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Sender: present the next request at the falling edge, hold it
    // until accepted. Register writes and pauses wait for an empty
    // pipeline first.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        logic         next_valid;
        logic         next_we;
        pending_req_t head;
        next_valid = s_valid && !req_taken;
        next_we    = 1'b0;
        if (aresetn && !next_valid && pending_requests.size() != 0) begin
            head = pending_requests[0];
            if (head.kind == REQ_BLOCK) begin
                // Idle at random, except inside the calm stretch
                if (head.calm || $urandom_range(99) >= IDLE_PERCENT) begin
                    next_valid = 1'b1;
                    s_block      <= head.block;
                    calm_stretch <= head.calm;
                    void'(pending_requests.pop_front());
                end
            end else if (expected_pixels.size() != 0) begin
                quiet_cycles = 0;
            end else if (quiet_cycles < SETTLE_CYCLES) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
                if (head.kind == REQ_CONFIG) begin
                    next_we = 1'b1;
                    cfg_index <= head.cfg_index;
                    cfg_wdata <= head.cfg_data;
                end
                void'(pending_requests.pop_front());
            end
        end
        s_valid   <= next_valid;
        cfg_wr_en <= next_we;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ---------------------------------------------------------------
    // Monitor: track register writes, predict on each accepted request,
    // check each accepted result against the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_quad_t got;
        pixel_quad_t want;
        string       field_names[4];
        field_names = '{"pixel_top_left", "pixel_top_right",
                        "pixel_bottom_left", "pixel_bottom_right"};
        req_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                cfg_writes++;
                case (cfg_index)
                    REG_OUTPUT_MODE: mode_shadow = cfg_wdata;
                    REG_RGBA_ORDER:  order_shadow = cfg_wdata[0];
                    default: ;                       // drop writes to spare indexes
                endcase
            end

            if (s_valid && s_ready) begin
                expected_pixels.push_back(convert_block(s_block, mode_shadow, order_shadow));
                mode_hits[mode_shadow]++;
            end

            if (m_valid && m_ready) begin
                results_seen++;
                got = {m_pixel_bottom_right, m_pixel_bottom_left,
                       m_pixel_top_right, m_pixel_top_left};
                if (expected_pixels.size() == 0) begin
                    note_error($sformatf("result %08h %08h %08h %08h with nothing expected",
                                         got[0], got[1], got[2], got[3]));
                end else begin
                    want = expected_pixels.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[k] !== want[k])
                            note_error($sformatf("%s: expected %08h, got %08h",
                                                 field_names[k], want[k], got[k]));
                    end
                end
            end

            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: give up when nothing has moved for too long
    always @(posedge aclk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results still due",
                     STALL_LIMIT, expected_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        yuv_block_t blk;
        int         next_switch;

        // Reset values first: opaque alpha, blue in byte 0
        queue_block(flat_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
        queue_block(flat_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
        queue_block(flat_block(8'd16, 8'd128, 8'd128, 8'd16, 8'd128), 1'b0);
        queue_block(flat_block(8'd235, 8'd128, 8'd128, 8'd235, 8'd128), 1'b0);
        blk = flat_block(8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
        blk.luma = {8'd235, 8'd16, 8'd255, 8'd0};
        queue_block(blk, 1'b0);
        queue_block(flat_block(8'd128, 8'd255, 8'd0, 8'd255, 8'd255), 1'b0);

        // Three-byte mode with red in byte 0: byte 3 must read zero
        queue_config(REG_OUTPUT_MODE, MODE_RGB24);
        queue_config(REG_RGBA_ORDER, 2'd1);
        queue_block(flat_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
        queue_block(blk, 1'b0);

        // Alpha from the alpha block, across its extremes
        queue_config(REG_OUTPUT_MODE, MODE_ALPHA_PLANE);
        blk = flat_block(8'd128, 8'd100, 8'd200, 8'd0, 8'd0);
        blk.alpha_luma = {8'd235, 8'd16, 8'd255, 8'd0};
        queue_block(blk, 1'b0);
        queue_block(flat_block(8'd60, 8'd30, 8'd220, 8'd255, 8'd255), 1'b0);
        queue_block(flat_block(8'd200, 8'd180, 8'd40, 8'd16, 8'd128), 1'b0);

        // Only bit 0 of the byte-order register counts
        queue_config(REG_RGBA_ORDER, 2'd2);
        queue_block(random_block(), 1'b0);

        // Spare selector behaves as opaque
        queue_config(REG_OUTPUT_MODE, MODE_SPARE);
        queue_block(random_block(), 1'b0);

        // Writes to spare indexes must change nothing
        queue_config(REG_SPARE_LO, 2'd3);
        queue_config(REG_SPARE_HI, 2'd1);
        queue_block(random_block(), 1'b0);
        queue_config(REG_RGBA_ORDER, 2'd3);
        queue_block(random_block(), 1'b0);

        // Random part, in phases of random register settings
        next_switch = 0;
        for (int i = 0; i < RANDOM_BLOCKS; i++) begin
            if (i == next_switch) begin
                queue_config(REG_OUTPUT_MODE, 2'($urandom_range(3)));
                queue_config(REG_RGBA_ORDER, 2'($urandom_range(3)));
                if ($urandom_range(3) == 0)
                    queue_config($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                 2'($urandom_range(3)));
                next_switch += $urandom_range(60, 200);
            end
            // Hold off once until the pipeline has fully drained
            if (i == 300)
                pending_requests.push_back('{REQ_PAUSE, '0, '0, '0, 1'b0});
            queue_block(random_block(), (i >= 500 && i < 700));
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Converted %0d blocks over %0d register writes;",
                 results_seen, cfg_writes);
        $display("per output mode 0..3: %0d %0d %0d %0d; both byte orders, clipping %s%0d errors",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 "at both rails and back-pressure stalls exercised; ", error_count);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
